/* rtl/kws_pkg.sv */
`default_nettype none
package kws_pkg;

  localparam int unsigned NumLetters = 26;
  localparam int unsigned NumSymbols = 36;
  localparam int unsigned SymW       = 6;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = 2;
  localparam int unsigned QCntW      = 3;

  localparam logic [SymW-1:0] LastSym  = SymW'(NumSymbols - 1);
  localparam logic [SymW-1:0] SymCount = SymW'(NumSymbols);
  localparam logic [SymW-1:0] LetCount = SymW'(NumLetters);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_KEY    = 2'd1,
    OP_FINISH = 2'd2,
    OP_DATA   = 2'd3
  } op_e;

  // decoded word passed from front to back
  typedef struct packed {
    op_e             op;
    logic [7:0]      ch;
    logic [SymW-1:0] sym;     // symbol code of the upper-cased byte
    logic            sym_ok;  // byte (upper-cased) is A-Z or 0-9
    logic            lower;   // byte is a-z
  } item_t;

endpackage
`default_nettype wire

/* rtl/kws_front.sv */
`default_nettype none
module kws_front
  import kws_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] in_op_i,
  input  wire logic [7:0] in_ch_i,
  output logic            head_valid_o,
  output item_t           head_o,
  input  wire logic       pop_i
);

  item_t             q_mem [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              push, pop;
  logic [7:0]        upc;
  item_t             dec;

  always_comb begin
    dec.op    = op_e'(in_op_i);
    dec.ch    = in_ch_i;
    dec.lower = (in_ch_i >= 8'h61) && (in_ch_i <= 8'h7a);
    upc       = dec.lower ? (in_ch_i - 8'h20) : in_ch_i;
    dec.sym   = '0;
    dec.sym_ok = 1'b0;
    if ((upc >= 8'h41) && (upc <= 8'h5a)) begin
      dec.sym    = SymW'(upc - 8'h41);
      dec.sym_ok = 1'b1;
    end else if ((upc >= 8'h30) && (upc <= 8'h39)) begin
      dec.sym    = SymW'(upc - 8'h30) + LetCount;
      dec.sym_ok = 1'b1;
    end
  end

  assign in_ready_o   = (cnt_q != QCntW'(QDepth));
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(push);
    rd_ptr_d = rd_ptr_q + QPtrW'(pop);
    cnt_d    = cnt_q + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/kws_back.sv */
`default_nettype none
module kws_back
  import kws_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       head_valid_i,
  input  wire item_t      head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_LOOK = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [SymW-1:0]        keyed_mem [NumSymbols];
  logic [SymW-1:0]        inv_mem   [NumSymbols];
  logic [NumSymbols-1:0]  used_q, used_d;
  logic [SymW-1:0]        fill_q, fill_d;
  logic [SymW-1:0]        walk_q, walk_d;
  logic                   ready_q, ready_d;
  logic                   dir_q;
  logic                   lower_q, lower_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_data_q, out_data_d;
  logic [SymW-1:0]        keyed_rd_q, inv_rd_q;
  logic                   rd_en;
  logic [SymW-1:0]        rd_addr;
  logic                   place_en;
  logic [SymW-1:0]        place_sym;
  logic                   can_load;
  logic [SymW-1:0]        r_sym;
  logic [7:0]             r_chr;

  assign can_load = !out_valid_q || out_ready_i;
  assign r_sym    = dir_q ? inv_rd_q : keyed_rd_q;

  always_comb begin
    if (r_sym < LetCount) begin
      r_chr = (lower_q ? 8'h61 : 8'h41) + 8'(r_sym);
    end else begin
      r_chr = 8'h30 + 8'(r_sym - LetCount);
    end
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    fill_d      = fill_q;
    walk_d      = walk_q;
    ready_d     = ready_q;
    lower_d     = lower_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_i.sym;
    place_en    = 1'b0;
    place_sym   = head_i.sym;
    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.op)
            OP_CLEAR: begin
              pop_o   = 1'b1;
              used_d  = '0;
              fill_d  = '0;
              ready_d = 1'b0;
            end
            OP_KEY: begin
              pop_o = 1'b1;
              if (!ready_q && head_i.sym_ok && !head_i.lower) begin
                place_en = !used_q[head_i.sym] && (fill_q < SymCount);
              end
            end
            OP_FINISH: begin
              pop_o   = 1'b1;
              walk_d  = LastSym;
              state_d = ST_FILL;
            end
            OP_DATA: begin
              if (can_load) begin
                pop_o = 1'b1;
                if (ready_q && head_i.sym_ok) begin
                  rd_en   = 1'b1;
                  lower_d = head_i.lower;
                  state_d = ST_LOOK;
                end else begin
                  out_valid_d = 1'b1;
                  out_data_d  = head_i.ch;
                end
              end
            end
            default: ;
          endcase
        end
      end
      // digits 9..0 then letters Z..A are codes 35 down to 0
      ST_FILL: begin
        place_sym = walk_q;
        place_en  = !used_q[walk_q] && (fill_q < SymCount);
        if (walk_q == '0) begin
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          walk_d = walk_q - 1'b1;
        end
      end
      ST_LOOK: begin
        out_valid_d = 1'b1;
        out_data_d  = r_chr;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (place_en) begin
      used_d[place_sym] = 1'b1;
      fill_d            = fill_q + 1'b1;
    end
  end

  // both tables written together so the inverse stays consistent
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      keyed_mem[fill_q]  <= place_sym;
      inv_mem[place_sym] <= fill_q;
    end
    if (rd_en) begin
      keyed_rd_q <= keyed_mem[rd_addr];
      inv_rd_q   <= inv_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    lower_q    <= lower_d;
    walk_q     <= walk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      fill_q      <= '0;
      ready_q     <= 1'b0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      fill_q      <= fill_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

/* rtl/keyword_substitution_cipher.sv */
// Channel   | Direction | Payload
// s_axis    | in        | tuser: opcode[1:0]; tdata: char_in[7:0]
// m_axis    | out       | tdata: char_out[7:0] (data words only)
// cfg       | in        | cfg_wdata_i: direction
//
// Words enter a 4-deep queue at up to one per cycle while it is not full; the back end drains it.
// Clear and key words are handled in ST_IDLE; finish walks all 36 symbols in ST_FILL.
// Data words are passed through, or looked up by a registered table read and sent from ST_LOOK.
// A stalled m_axis holds further data words in the queue; reset is async.
`default_nettype none
module keyword_substitution_cipher
  import kws_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // char_in[7:0]
  input  wire logic [1:0] s_axis_tuser,   // opcode[1:0]
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // char_out[7:0]
);

  logic  head_valid;
  item_t head;
  logic  pop;

  kws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_ch_i      (s_axis_tdata),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  kws_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule
`default_nettype wire
